>>> rtl/core/hash_table_quadratic_probe_unit_defines.svh
// Assertion macros shared by the hash table probe unit RTL.
`ifndef HASH_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH
`define HASH_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define HQP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hqp check failed");
// Clocked check that also runs through reset.
`define HQP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hqp check failed");
`else
`define HQP_ASSERT(lbl, clk, rst_n, prop)
`define HQP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/hqp_pkg.sv
// Shared constants and codes for the hash table probe unit.
`default_nettype none
package hqp_pkg;

    localparam int TABLE_SIZE_DEF = 31;
    localparam int Q_DEPTH_DEF    = 2;

    localparam int FUNC_W      = 1;
    localparam int KEY_W       = 31;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_PORT_W = 5;
    localparam int ENTRIES_W   = 5;

    // key reduction: CHUNK_W key bits folded per cycle
    localparam int CHUNK_W    = 8;
    localparam int KEY_CHUNKS = (KEY_W + CHUNK_W - 1) / CHUNK_W;
    localparam int KEY_PAD_W  = KEY_CHUNKS * CHUNK_W;

    localparam logic [FUNC_W-1:0] FN_SEARCH = 1'b0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage
`default_nettype wire

>>> rtl/core/hqp_front.sv
// Front end: takes requests and reduces the key to its home slot.
`default_nettype none
module hqp_front #(
    parameter int TABLE_SIZE = hqp_pkg::TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hold,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hqp_pkg::FUNC_W-1:0]  i_func,
    input  logic [hqp_pkg::KEY_W-1:0]   i_key,
    input  logic [hqp_pkg::VALUE_W-1:0] i_value,
    output logic                        o_push,
    input  logic                        i_q_full,
    output logic [hqp_pkg::FUNC_W-1:0]  o_func,
    output logic [hqp_pkg::KEY_W-1:0]   o_key,
    output logic [hqp_pkg::VALUE_W-1:0] o_value,
    output logic [$clog2(TABLE_SIZE)-1:0] o_home
);
    import hqp_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int SLOT_WE = SLOT_W + 1;
    localparam int STEP_W  = (KEY_CHUNKS > 1) ? $clog2(KEY_CHUNKS) : 1;
    localparam logic [SLOT_WE-1:0] T_EXT = SLOT_WE'(TABLE_SIZE);

    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_CALC = 3'b010,
        FR_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [KEY_PAD_W-1:0] r_bits, n_bits;
    logic [SLOT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;

    logic                 w_accept;
    logic [SLOT_W-1:0]    w_rem;
    logic [SLOT_WE-1:0]   w_t;

    assign o_stall  = i_hold || !((r_state == FR_IDLE) || ((r_state == FR_PUSH) && !i_q_full));
    assign w_accept = i_valid && !o_stall;
    assign o_push   = (r_state == FR_PUSH) && !i_q_full;
    assign o_func   = r_func;
    assign o_key    = r_key;
    assign o_value  = r_value;
    assign o_home   = r_rem;

    // remainder = (2*rem + bit) mod TABLE_SIZE, MSB first over one chunk
    always_comb begin
        w_rem = r_rem;
        w_t   = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            w_t = {w_rem, r_bits[KEY_PAD_W-1-i]};
            if (w_t >= T_EXT) begin
                w_t = w_t - T_EXT;
            end
            w_rem = w_t[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_key   = r_key;
        n_value = r_value;
        n_bits  = r_bits;
        n_rem   = r_rem;
        n_step  = r_step;
        case (r_state)
            FR_IDLE: begin
                n_state = FR_IDLE;
            end
            FR_CALC: begin
                n_bits = r_bits << CHUNK_W;
                n_rem  = w_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(KEY_CHUNKS - 1)) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (o_push) begin
                    n_state = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
        if (w_accept) begin
            n_state = FR_CALC;
            n_func  = i_func;
            n_key   = i_key;
            n_value = i_value;
            n_bits  = KEY_PAD_W'(i_key);
            n_rem   = '0;
            n_step  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_key   <= n_key;
        r_value <= n_value;
        r_bits  <= n_bits;
        r_rem   <= n_rem;
        r_step  <= n_step;
    end

endmodule
`default_nettype wire

>>> rtl/core/hqp_queue.sv
// Small FIFO between the front end and the probe engine.
`default_nettype none
module hqp_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = hqp_pkg::Q_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    import hqp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/hqp_back.sv
// Probe engine: key/value memories, quadratic probe walk and result register.
`default_nettype none
`include "hash_table_quadratic_probe_unit_defines.svh"
module hqp_back #(
    parameter int TABLE_SIZE = hqp_pkg::TABLE_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    output logic                            o_clearing,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    input  logic [hqp_pkg::FUNC_W-1:0]      i_func,
    input  logic [hqp_pkg::KEY_W-1:0]       i_key,
    input  logic [hqp_pkg::VALUE_W-1:0]     i_value,
    input  logic [$clog2(TABLE_SIZE)-1:0]   i_home,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [hqp_pkg::STATUS_W-1:0]    o_status,
    output logic [hqp_pkg::SLOT_PORT_W-1:0] o_slot,
    output logic [hqp_pkg::VALUE_W-1:0]     o_stored_value,
    output logic [hqp_pkg::ENTRIES_W-1:0]   o_entries
);
    import hqp_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int SLOT_WE = SLOT_W + 1;
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam logic [SLOT_WE-1:0] T_EXT   = SLOT_WE'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0]  T_LAST  = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [SLOT_W-1:0]  STEP2   = SLOT_W'(2);

    typedef enum logic [3:0] {
        BK_CLEAR = 4'b0001,
        BK_IDLE  = 4'b0010,
        BK_READ  = 4'b0100,
        BK_CHECK = 4'b1000
    } t_back_state;

    function automatic logic [SLOT_W-1:0] f_mod_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_WE-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= T_EXT) begin
            s = s - T_EXT;
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] f_mod_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_WE-1:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + T_EXT - {1'b0, b};
        end
        return s[SLOT_W-1:0];
    endfunction

    logic [KEY_W-1:0]   r_key_mem [TABLE_SIZE];
    logic [VALUE_W-1:0] r_val_mem [TABLE_SIZE];

    t_back_state        r_state, n_state;
    logic [SLOT_W-1:0]  r_addr, n_addr;
    logic [SLOT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0]  r_sq, n_sq;
    logic [SLOT_W-1:0]  r_add, n_add;
    logic [SLOT_W-1:0]  r_home, n_home;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [KEY_W-1:0]   r_rd_key;
    logic [VALUE_W-1:0] r_rd_val;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [VALUE_W-1:0] r_out_val, n_out_val;
    logic [CNT_W-1:0]   r_out_entries, n_out_entries;

    logic               w_out_free, w_out_load;
    logic               w_hit, w_empty, w_last;
    logic               w_key_we, w_val_we;
    logic [KEY_W-1:0]   w_key_wd;
    logic [SLOT_W-1:0]  w_sq_next;

    assign o_clearing     = (r_state == BK_CLEAR);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = SLOT_PORT_W'(r_out_slot);
    assign o_stored_value = r_out_val;
    assign o_entries      = ENTRIES_W'(r_out_entries);

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_hit      = (r_rd_key == r_key);
    assign w_empty    = (r_rd_key == '0);
    assign w_last     = (r_cnt == T_LAST);
    assign w_sq_next  = f_mod_add(r_sq, r_add);

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_cnt         = r_cnt;
        n_sq          = r_sq;
        n_add         = r_add;
        n_home        = r_home;
        n_func        = r_func;
        n_key         = r_key;
        n_value       = r_value;
        n_count       = r_count;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_val     = r_out_val;
        n_out_entries = r_out_entries;
        w_out_load    = 1'b0;
        w_key_we      = 1'b0;
        w_val_we      = 1'b0;
        w_key_wd      = r_key;
        o_pop         = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                w_key_we = 1'b1;
                w_key_wd = '0;
                if (r_addr == T_LAST) begin
                    n_addr  = '0;
                    n_state = BK_IDLE;
                end else begin
                    n_addr = r_addr + SLOT_W'(1);
                end
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_key == '0) begin
                        // reserved key: answer a miss without touching the table
                        if (w_out_free) begin
                            o_pop         = 1'b1;
                            w_out_load    = 1'b1;
                            n_out_status  = ST_MISS;
                            n_out_slot    = '0;
                            n_out_val     = '0;
                            n_out_entries = r_count;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_func  = i_func;
                        n_key   = i_key;
                        n_value = i_value;
                        n_home  = i_home;
                        n_addr  = i_home;
                        n_cnt   = '0;
                        n_sq    = '0;
                        n_add   = SLOT_W'(1);
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_CHECK;
            end
            BK_CHECK: begin
                if (w_hit || w_empty || w_last) begin
                    if (w_out_free) begin
                        w_out_load    = 1'b1;
                        n_state       = BK_IDLE;
                        n_out_status  = ST_MISS;
                        n_out_slot    = '0;
                        n_out_val     = '0;
                        n_out_entries = r_count;
                        if (r_func == FN_SEARCH) begin
                            if (w_hit) begin
                                n_out_status = ST_FOUND;
                                n_out_slot   = r_addr;
                                n_out_val    = r_rd_val;
                            end
                        end else if (w_hit) begin
                            w_val_we     = 1'b1;
                            n_out_status = ST_UPDATED;
                            n_out_slot   = r_addr;
                            n_out_val    = r_value;
                        end else if (w_empty) begin
                            w_key_we      = 1'b1;
                            w_val_we      = 1'b1;
                            n_count       = r_count + CNT_W'(1);
                            n_out_status  = ST_INSERTED;
                            n_out_slot    = r_addr;
                            n_out_val     = r_value;
                            n_out_entries = r_count + CNT_W'(1);
                        end else begin
                            n_out_status = ST_FULL;
                        end
                    end
                end else begin
                    // next probe: +k*k after an even probe number, -k*k after an odd one
                    n_cnt   = r_cnt + SLOT_W'(1);
                    n_state = BK_READ;
                    if (!r_cnt[0]) begin
                        n_sq   = w_sq_next;
                        n_add  = f_mod_add(r_add, STEP2);
                        n_addr = f_mod_add(r_home, w_sq_next);
                    end else begin
                        n_addr = f_mod_sub(r_home, r_sq);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt         <= n_cnt;
        r_sq          <= n_sq;
        r_add         <= n_add;
        r_home        <= n_home;
        r_func        <= n_func;
        r_key         <= n_key;
        r_value       <= n_value;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_val     <= n_out_val;
        r_out_entries <= n_out_entries;
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[r_addr] <= w_key_wd;
        end
        r_rd_key <= r_key_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_val_mem[r_addr] <= r_value;
        end
        r_rd_val <= r_val_mem[r_addr];
    end

    `HQP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == BK_CLEAR) && !r_out_valid)
    `HQP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_SIZE))
    `HQP_ASSERT(a_no_pop_clear, i_clk, i_rst_n, (r_state == BK_CLEAR) |-> !o_pop)
    `HQP_ASSERT(a_insert_counts, i_clk, i_rst_n, w_out_load && (n_out_status == ST_INSERTED) |=> (r_count == $past(r_count) + CNT_W'(1)))
    `HQP_ASSERT(a_key_write_ok, i_clk, i_rst_n, w_key_we |-> (r_state == BK_CLEAR) || w_out_load)

endmodule
`default_nettype wire

>>> rtl/core/hash_table_quadratic_probe_unit.sv
// Top level of the open-addressing hash table with quadratic probing.
`default_nettype none
// Each request searches for or inserts a nonzero key; one result comes back per request.
// The front end takes a request and folds the key to key mod TABLE_SIZE (8 key
// bits per cycle), then hands it to the probe engine through a
// small queue, so it can start on the next request while earlier ones are probed.
// The probe engine picks up a request, then for each probe reads the key memory
// and compares (registered key memory read, then compare), visiting p slots,
// p between 1 and TABLE_SIZE; a zero key is answered with a miss at pick-up.
// After reset the
// key memory is cleared one slot per cycle, with o_stall high.
module hash_table_quadratic_probe_unit #(
    parameter int TABLE_SIZE = hqp_pkg::TABLE_SIZE_DEF,
    parameter int Q_DEPTH    = hqp_pkg::Q_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [hqp_pkg::FUNC_W-1:0]      i_func,
    input  logic [hqp_pkg::KEY_W-1:0]       i_key,
    input  logic [hqp_pkg::VALUE_W-1:0]     i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [hqp_pkg::STATUS_W-1:0]    o_status,
    output logic [hqp_pkg::SLOT_PORT_W-1:0] o_slot,
    output logic [hqp_pkg::VALUE_W-1:0]     o_stored_value,
    output logic [hqp_pkg::ENTRIES_W-1:0]   o_entries
);
    import hqp_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int Q_W    = FUNC_W + KEY_W + VALUE_W + SLOT_W;

    logic                w_clearing;
    logic                w_push, w_q_full, w_pop, w_q_empty;
    logic [FUNC_W-1:0]   w_f_func, w_b_func;
    logic [KEY_W-1:0]    w_f_key, w_b_key;
    logic [VALUE_W-1:0]  w_f_value, w_b_value;
    logic [SLOT_W-1:0]   w_f_home, w_b_home;
    logic [Q_W-1:0]      w_q_wdata, w_q_rdata;

    assign w_q_wdata = {w_f_func, w_f_key, w_f_value, w_f_home};
    assign {w_b_func, w_b_key, w_b_value, w_b_home} = w_q_rdata;

    hqp_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hold   (w_clearing),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .i_key    (i_key),
        .i_value  (i_value),
        .o_push   (w_push),
        .i_q_full (w_q_full),
        .o_func   (w_f_func),
        .o_key    (w_f_key),
        .o_value  (w_f_value),
        .o_home   (w_f_home)
    );

    hqp_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    hqp_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_clearing     (w_clearing),
        .i_q_empty      (w_q_empty),
        .o_pop          (w_pop),
        .i_func         (w_b_func),
        .i_key          (w_b_key),
        .i_value        (w_b_value),
        .i_home         (w_b_home),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_stored_value (o_stored_value),
        .o_entries      (o_entries)
    );

endmodule
`default_nettype wire

>>> sim/hash_table_quadratic_probe_unit_test.sv
// Self-checking testbench for the quadratic-probe hash table unit: mirrored table, directed and random requests.
`default_nettype none
module hash_table_quadratic_probe_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hqp_pkg::*;

    localparam int STALL_PCT   = 23;
    localparam int RANDOM_REQS = 1400;
    localparam int DRAIN_TAIL  = 80;    // longer than a full 31-probe walk
    localparam int IDLE_LIMIT  = 3000;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_PORT_W-1:0] slot;
        logic [VALUE_W-1:0]     value;
        logic [ENTRIES_W-1:0]   entries;
    } t_table_reply;

    // Mirror of the slot store; each accepted request updates it and queues the reply it implies.
    class t_hash_table_mirror;
        localparam int SLOTS = TABLE_SIZE_DEF;
        logic [KEY_W-1:0]     keys[SLOTS];
        logic [VALUE_W-1:0]   vals[SLOTS];
        logic [ENTRIES_W-1:0] occupied;
        t_table_reply         awaited_replies[$];
        int                   errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                keys[i] = '0;
                vals[i] = '0;
            end
            occupied = '0;
            errors = 0;
        endfunction

        function int unsigned probe_slot(int unsigned home, int unsigned c);
            int unsigned k;
            int unsigned off;
            k = (c + 1) / 2;
            off = (k * k) % SLOTS;
            if (c % 2 == 1)
                return (home + off) % SLOTS;
            return (home + SLOTS - off) % SLOTS;
        endfunction

        function void apply_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
                                    logic [VALUE_W-1:0] v);
            t_table_reply rep;
            int unsigned  home;
            int unsigned  p;
            int           hit_at;
            int           free_at;
            rep.status = ST_MISS;
            rep.slot = '0;
            rep.value = '0;
            if (k != '0) begin
                home = k % SLOTS;
                hit_at = -1;
                free_at = -1;
                for (int unsigned c = 0; c < SLOTS && hit_at < 0 && free_at < 0; c++) begin
                    p = probe_slot(home, c);
                    if (keys[p] == k)
                        hit_at = p;
                    else if (keys[p] == '0)
                        free_at = p;
                end
                if (fn == FN_SEARCH) begin
                    if (hit_at >= 0) begin
                        rep.status = ST_FOUND;
                        rep.slot = SLOT_PORT_W'(hit_at);
                        rep.value = vals[hit_at];
                    end
                end else if (hit_at >= 0) begin
                    vals[hit_at] = v;
                    rep.status = ST_UPDATED;
                    rep.slot = SLOT_PORT_W'(hit_at);
                    rep.value = v;
                end else if (free_at >= 0) begin
                    keys[free_at] = k;
                    vals[free_at] = v;
                    occupied++;
                    rep.status = ST_INSERTED;
                    rep.slot = SLOT_PORT_W'(free_at);
                    rep.value = v;
                end else begin
                    rep.status = ST_FULL;
                end
            end
            rep.entries = occupied;
            awaited_replies.push_back(rep);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void match_reply(t_table_reply got);
            t_table_reply exp;
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, got status %0d slot %0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            exp = awaited_replies.pop_front();
            compare_field("status", 32'(exp.status), 32'(got.status));
            compare_field("slot", 32'(exp.slot), 32'(got.slot));
            compare_field("stored_value", exp.value, got.value);
            compare_field("entries", 32'(exp.entries), 32'(got.entries));
        endfunction

        function int waiting();
            return awaited_replies.size();
        endfunction

        // Random key already in the table, or zero when the table is empty.
        function logic [KEY_W-1:0] pick_stored_key();
            int start;
            start = $urandom_range(0, SLOTS - 1);
            for (int i = 0; i < SLOTS; i++)
                if (keys[(start + i) % SLOTS] != '0)
                    return keys[(start + i) % SLOTS];
            return '0;
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [FUNC_W-1:0]      i_func = FN_SEARCH;
    logic [KEY_W-1:0]       i_key = '0;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [SLOT_PORT_W-1:0] o_slot;
    logic [VALUE_W-1:0]     o_stored_value;
    logic [ENTRIES_W-1:0]   o_entries;

    t_hash_table_mirror mirror = new();
    bit                 steady = 1'b0;   // no idling on either side while set

    hash_table_quadratic_probe_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_stored_value (o_stored_value),
        .o_entries      (o_entries)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
                                logic [VALUE_W-1:0] v);
        while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        mirror.apply_request(fn, k, v);
    endtask

    task automatic wait_for_replies();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.waiting() != 0);
    endtask

    // Random key; half of them forced onto home slot 0, the last slot or a random home slot.
    function automatic logic [KEY_W-1:0] make_key();
        int unsigned r;
        int unsigned home;
        r = $urandom & 32'h7fff_ffff;
        if ($urandom_range(0, 1) == 0)
            return r[KEY_W-1:0];
        case ($urandom_range(0, 2))
            0:       home = 0;
            1:       home = TABLE_SIZE_DEF - 1;
            default: home = $urandom_range(0, TABLE_SIZE_DEF - 1);
        endcase
        r = r - (r % TABLE_SIZE_DEF) + home;
        if (r > 32'h7fff_ffff)
            r -= TABLE_SIZE_DEF;
        if (r == 0)
            r = TABLE_SIZE_DEF;
        return r[KEY_W-1:0];
    endfunction

    // Receive side: check accepted replies, stall at random.
    initial begin
        t_table_reply got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.status = o_status;
                got.slot = o_slot;
                got.value = o_stored_value;
                got.entries = o_entries;
                mirror.match_reply(got);
            end
            i_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // Watchdog on cycles without any accepted request or reply.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_rst_n && i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("[hash_table_quadratic_probe_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0]   k;
        logic [FUNC_W-1:0]  fn;
        int                 pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero key, empty misses, collisions around slot 0 and 30, extremes
        send_request(FN_SEARCH, '0, 32'hffff_ffff);
        send_request(FN_INSERT, '0, 32'hffff_ffff);
        send_request(FN_SEARCH, 31'd5, 32'h0);
        send_request(FN_INSERT, 31'd31, 32'h0);
        send_request(FN_INSERT, 31'd62, 32'hffff_ffff);
        send_request(FN_INSERT, 31'd93, 32'h1357_9bdf);
        send_request(FN_INSERT, 31'd124, 32'h2468_ace0);
        send_request(FN_INSERT, 31'd30, 32'hdead_beef);
        send_request(FN_INSERT, 31'h7fff_ffff, 32'ha5a5_a5a5);
        send_request(FN_SEARCH, 31'h7fff_ffff, 32'h0);
        send_request(FN_INSERT, 31'h7fff_ffff, 32'h0);
        send_request(FN_SEARCH, 31'h7fff_ffff, 32'hffff_ffff);
        send_request(FN_SEARCH, 31'd93, 32'h0);
        send_request(FN_SEARCH, 31'd124, 32'h0);
        send_request(FN_SEARCH, 31'd155, 32'h0);
        send_request(FN_INSERT, 31'd62, 32'h1234_5678);
        send_request(FN_SEARCH, 31'd62, 32'h0);
        send_request(FN_SEARCH, 31'd30, 32'h0);
        send_request(FN_INSERT, 31'h2aaa_aaaa, 32'h5555_5555);
        send_request(FN_INSERT, 31'h5555_5555, 32'haaaa_aaaa);
        send_request(FN_SEARCH, 31'h2aaa_aaaa, 32'h0);
        send_request(FN_SEARCH, '0, 32'h0);
        wait_for_replies();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 300 && n < 500);
            if (n == 700 || $urandom_range(0, 199) == 0)
                wait_for_replies();
            pick = $urandom_range(0, 99);
            k = mirror.pick_stored_key();
            if (k == '0)
                k = make_key();
            if (pick < 3) begin
                send_request(FN_INSERT, make_key(), $urandom);
            end else if (pick < 43) begin
                send_request(FN_SEARCH, k, $urandom);
            end else if (pick < 63) begin
                send_request(FN_INSERT, k, $urandom);
            end else if (pick < 84) begin
                send_request(FN_SEARCH, make_key(), $urandom);
            end else if (pick < 96) begin
                // noise: mostly searches so the table does not fill at once
                fn = ($urandom_range(0, 3) == 0) ? FN_INSERT : FN_SEARCH;
                send_request(fn, KEY_W'($urandom), $urandom);
            end else begin
                fn = ($urandom_range(0, 1) == 0) ? FN_INSERT : FN_SEARCH;
                send_request(fn, '0, $urandom);
            end
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.waiting() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.waiting() == 0) begin
            $display("[hash_table_quadratic_probe_unit] OK");
        end else begin
            $display("[hash_table_quadratic_probe_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
